[hw/rtl/scfr_pkg.sv]
// Shared constants for the sync-marked CRC-16 frame receiver.
package scfr_pkg;

    localparam int PAYLOAD_WORDS = 16;
    localparam int PAYLOAD_BYTES = 4 * PAYLOAD_WORDS;
    localparam int FRAME_LEN     = PAYLOAD_BYTES + 4;

    localparam int RX_W   = 8;
    localparam int IDX_W  = 4;
    localparam int WORD_W = 32;
    localparam int CRC_W  = 16;

    localparam int ADDR_W = $clog2(FRAME_LEN);
    localparam int CNT_W  = $clog2(FRAME_LEN + 1);
    localparam int WCNT_W = (PAYLOAD_WORDS > 1) ? $clog2(PAYLOAD_WORDS) : 1;

    localparam logic [RX_W-1:0]  SYNC_A   = 8'd117;
    localparam logic [RX_W-1:0]  SYNC_B   = 8'd84;
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'hA001;

    localparam logic KIND_WORD = 1'b0;
    localparam logic KIND_ERR  = 1'b1;

endpackage

[hw/rtl/scfr_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module scfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 68,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[hw/rtl/sync_crc_frame_receiver.sv]
// Top level: byte-serial deframer for sync-marked, CRC-16 protected frames.
//
//   channel | direction | ports                                      | per beat
//   --------+-----------+--------------------------------------------+----------------------
//   s_      | in        | s_valid s_ready s_rx_byte                  | one received byte
//   m_      | out       | m_valid m_ready m_kind m_word_index        | one payload word or
//           |           | m_payload_word m_last                      | one CRC error result
//
// A byte that does not complete a frame is taken in idle, where s_ready stays high.
// A frame-completing byte starts one pass over the 68-entry store through its single
// read port: 68 reads, then a decision in the check state. A good frame then emits
// each payload word after 4 byte reads and a load of the output register.
// Output stalls hold the block in place; s_ready is low until the frame is done.
// Reset clears the fill count, the ring base and the output valid; the store needs no
// clearing pass, since only bytes written since the frame began are ever read.
module sync_crc_frame_receiver (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_kind,
    output logic [3:0]  m_word_index,
    output logic [31:0] m_payload_word,
    output logic        m_last
);

    localparam int ADDR_W = scfr_pkg::ADDR_W;
    localparam int CNT_W  = scfr_pkg::CNT_W;
    localparam int SUM_W  = scfr_pkg::CNT_W + 1;
    localparam int WCNT_W = scfr_pkg::WCNT_W;

    typedef enum logic [2:0] {
        ST_IDLE,      // take bytes, one per beat
        ST_SCAN,      // CRC pass and sync search over the full frame
        ST_CHECK,     // decide good frame or error and resync
        ST_EMIT_RD,   // gather four payload bytes into one word
        ST_EMIT_OUT   // hand the word to the output register
    } state_t;

    // The store is a ring: logical byte i lives at (base + i) mod FRAME_LEN.
    // Resync then moves the base instead of copying bytes down.
    function automatic logic [ADDR_W-1:0] ring_addr(input logic [ADDR_W-1:0] base,
                                                    input logic [CNT_W-1:0]  idx);
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(base) + SUM_W'(idx);
        if (sum >= SUM_W'(scfr_pkg::FRAME_LEN)) begin
            sum = sum - SUM_W'(scfr_pkg::FRAME_LEN);
        end
        return ADDR_W'(sum);
    endfunction

    // Reflected CRC-16 update, one byte per call.
    function automatic logic [scfr_pkg::CRC_W-1:0] crc_byte(
        input logic [scfr_pkg::CRC_W-1:0] crc,
        input logic [scfr_pkg::RX_W-1:0]  b
    );
        logic [scfr_pkg::CRC_W-1:0] c;
        c = crc ^ scfr_pkg::CRC_W'(b);
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ scfr_pkg::CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    state_t                        state_reg, state_next;
    logic [ADDR_W-1:0]             fill_reg, fill_next;
    logic [ADDR_W-1:0]             base_reg, base_next;
    logic [CNT_W-1:0]              cnt_reg, cnt_next;
    logic                          pend_reg, pend_next;
    logic [CNT_W-1:0]              pidx_reg, pidx_next;
    logic [scfr_pkg::CRC_W-1:0]    crc_reg, crc_next;
    logic [scfr_pkg::RX_W-1:0]     prev_reg, prev_next;
    logic                          found_reg, found_next;
    logic [CNT_W-1:0]              pos_reg, pos_next;
    logic                          tail_sync_reg, tail_sync_next;
    logic [scfr_pkg::WORD_W-1:0]   word_sr_reg, word_sr_next;
    logic [WCNT_W-1:0]             word_cnt_reg, word_cnt_next;

    logic                          m_valid_reg, m_valid_next;
    logic                          m_kind_reg, m_kind_next;
    logic [scfr_pkg::IDX_W-1:0]    m_idx_reg, m_idx_next;
    logic [scfr_pkg::WORD_W-1:0]   m_word_reg, m_word_next;
    logic                          m_last_reg, m_last_next;

    logic                          ram_we;
    logic [ADDR_W-1:0]             ram_waddr;
    logic [scfr_pkg::RX_W-1:0]     ram_wdata;
    logic                          ram_re;
    logic [ADDR_W-1:0]             ram_raddr;
    logic [scfr_pkg::RX_W-1:0]     ram_rdata;

    logic                          out_free;
    logic                          drop_hunt;
    logic                          drop_second;
    logic                          last_word;

    scfr_ram #(
        .WIDTH (scfr_pkg::RX_W),
        .DEPTH (scfr_pkg::FRAME_LEN)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign out_free  = !m_valid_reg || m_ready;
    // Hunting: anything but the first sync byte is dropped.
    assign drop_hunt   = (fill_reg == '0) && (s_rx_byte != scfr_pkg::SYNC_A);
    // Second sync byte wrong: drop it and start hunting again.
    assign drop_second = (fill_reg == ADDR_W'(1)) && (s_rx_byte != scfr_pkg::SYNC_B);
    assign last_word   = (word_cnt_reg == WCNT_W'(scfr_pkg::PAYLOAD_WORDS - 1));

    always_comb begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        base_next      = base_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pidx_next      = pidx_reg;
        crc_next       = crc_reg;
        prev_next      = prev_reg;
        found_next     = found_reg;
        pos_next       = pos_reg;
        tail_sync_next = tail_sync_reg;
        word_sr_next   = word_sr_reg;
        word_cnt_next  = word_cnt_reg;

        m_valid_next   = m_valid_reg;
        m_kind_next    = m_kind_reg;
        m_idx_next     = m_idx_reg;
        m_word_next    = m_word_reg;
        m_last_next    = m_last_reg;

        ram_we    = 1'b0;
        ram_waddr = ring_addr(base_reg, CNT_W'(fill_reg));
        ram_wdata = s_rx_byte;
        ram_re    = 1'b0;
        ram_raddr = ring_addr(base_reg, cnt_reg);

        // Retire the held result once the consumer takes it.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (drop_second) begin
                        fill_next = '0;
                    end else if (!drop_hunt) begin
                        ram_we = 1'b1;
                        if (fill_reg == ADDR_W'(scfr_pkg::FRAME_LEN - 1)) begin
                            // Frame full: start the check pass.
                            state_next = ST_SCAN;
                            cnt_next   = '0;
                            crc_next   = scfr_pkg::CRC_INIT;
                            found_next = 1'b0;
                            pos_next   = '0;
                            prev_next  = '0;
                        end else begin
                            fill_next = fill_reg + ADDR_W'(1);
                        end
                    end
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle; data returns from the registered read port in the next cycle.
                if (cnt_reg < CNT_W'(scfr_pkg::FRAME_LEN)) begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_addr(base_reg, cnt_reg);
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                    pidx_next = cnt_reg;
                end
                if (pend_reg) begin
                    crc_next  = crc_byte(crc_reg, ram_rdata);
                    prev_next = ram_rdata;
                    // Record the first sync pair starting at position 2 or later.
                    if (!found_reg && pidx_reg >= CNT_W'(3) &&
                        prev_reg == scfr_pkg::SYNC_A && ram_rdata == scfr_pkg::SYNC_B) begin
                        found_next = 1'b1;
                        pos_next   = pidx_reg - CNT_W'(1);
                    end
                    if (pidx_reg == CNT_W'(scfr_pkg::FRAME_LEN - 1)) begin
                        tail_sync_next = (ram_rdata == scfr_pkg::SYNC_A);
                        state_next     = ST_CHECK;
                    end
                end
            end

            ST_CHECK: begin
                if (crc_reg == '0) begin
                    state_next    = ST_EMIT_RD;
                    cnt_next      = '0;
                    word_cnt_next = '0;
                end else if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = scfr_pkg::KIND_ERR;
                    m_idx_next   = '0;
                    m_word_next  = '0;
                    m_last_next  = 1'b1;
                    state_next   = ST_IDLE;
                    if (found_reg) begin
                        // Rotate the ring so the sync pair becomes byte 0.
                        base_next = ring_addr(base_reg, pos_reg);
                        fill_next = ADDR_W'(CNT_W'(scfr_pkg::FRAME_LEN) - pos_reg);
                    end else if (tail_sync_reg) begin
                        // Keep the trailing first sync byte.
                        base_next = ring_addr(base_reg, CNT_W'(scfr_pkg::FRAME_LEN - 1));
                        fill_next = ADDR_W'(1);
                    end else begin
                        fill_next = '0;
                    end
                end
            end

            ST_EMIT_RD: begin
                // Four reads per word; hold off the fifth until the word is out.
                if (cnt_reg[1:0] != 2'b00 || !pend_reg) begin
                    ram_re    = 1'b1;
                    ram_raddr = ring_addr(base_reg, cnt_reg + CNT_W'(2));
                    cnt_next  = cnt_reg + CNT_W'(1);
                    pend_next = 1'b1;
                end
                if (pend_reg) begin
                    // Little-endian: each new byte enters at the top.
                    word_sr_next = {ram_rdata, word_sr_reg[scfr_pkg::WORD_W-1:8]};
                    if (cnt_reg[1:0] == 2'b00) begin
                        state_next = ST_EMIT_OUT;
                    end
                end
            end

            ST_EMIT_OUT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_kind_next  = scfr_pkg::KIND_WORD;
                    m_idx_next   = scfr_pkg::IDX_W'(word_cnt_reg);
                    m_word_next  = word_sr_reg;
                    m_last_next  = last_word;
                    if (last_word) begin
                        fill_next  = '0;
                        state_next = ST_IDLE;
                    end else begin
                        word_cnt_next = word_cnt_reg + WCNT_W'(1);
                        state_next    = ST_EMIT_RD;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        cnt_reg       <= cnt_next;
        pidx_reg      <= pidx_next;
        crc_reg       <= crc_next;
        prev_reg      <= prev_next;
        found_reg     <= found_next;
        pos_reg       <= pos_next;
        tail_sync_reg <= tail_sync_next;
        word_sr_reg   <= word_sr_next;
        word_cnt_reg  <= word_cnt_next;
        m_kind_reg    <= m_kind_next;
        m_idx_reg     <= m_idx_next;
        m_word_reg    <= m_word_next;
        m_last_reg    <= m_last_next;
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            fill_reg    <= '0;
            base_reg    <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            fill_reg    <= fill_next;
            base_reg    <= base_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_kind         = m_kind_reg;
    assign m_word_index   = m_idx_reg;
    assign m_payload_word = m_word_reg;
    assign m_last         = m_last_reg;

endmodule

[hw/rtl/scfr_checker.sv]
// Port-level checks for the frame receiver, bound to the top level.
module scfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [7:0]  s_rx_byte,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_kind,
    input logic [3:0]  m_word_index,
    input logic [31:0] m_payload_word,
    input logic        m_last
);

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_kind) && $stable(m_word_index)
                                   && $stable(m_payload_word) && $stable(m_last)))
        else $error("result beat changed while stalled");

    // An error result is a single, empty, final beat.
    a_err_shape: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == scfr_pkg::KIND_ERR) |->
            (m_last && m_word_index == '0 && m_payload_word == '0))
        else $error("malformed error result");

    // The final word of a good frame carries the last index.
    a_last_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == scfr_pkg::KIND_WORD && m_last) |->
            (m_word_index == scfr_pkg::IDX_W'(scfr_pkg::PAYLOAD_WORDS - 1)))
        else $error("last word has wrong index");

    // Input stays closed while a frame is still being emitted.
    a_emit_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == scfr_pkg::KIND_WORD && !m_last) |-> !s_ready)
        else $error("input open in the middle of a frame");

    // Ready drops only right after a byte was taken.
    a_ready_fall: assert property (@(posedge aclk) disable iff (!aresetn)
        ($past(aresetn) && $fell(s_ready)) |-> $past(s_valid))
        else $error("input ready dropped without an accepted byte");

endmodule

bind sync_crc_frame_receiver scfr_checker u_scfr_checker (.*);

[tb/sv/scfr_tb_pkg.sv]
// CRC-16 step and frame buffer type shared by the frame receiver testbench files.
package scfr_tb_pkg;

    import scfr_pkg::*;

    typedef logic [RX_W-1:0] frame_t [FRAME_LEN];

    // Reflected CRC-16, one byte, LSB first.
    function automatic logic [CRC_W-1:0] crc16_step(input logic [CRC_W-1:0] crc,
                                                    input logic [RX_W-1:0]  b);
        logic [CRC_W-1:0] c;
        c = crc ^ {{(CRC_W-RX_W){1'b0}}, b};
        repeat (8) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

[tb/sv/scfr_deframe_checker.sv]
// Predictor and result checker for the sync-marked CRC-16 frame receiver.
module scfr_deframe_checker
    import scfr_pkg::*;
    import scfr_tb_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [RX_W-1:0]   s_rx_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic              m_kind,
    input  logic [IDX_W-1:0]  m_word_index,
    input  logic [WORD_W-1:0] m_payload_word,
    input  logic              m_last,
    output int                mismatch_count,
    output int                results_due
);

    typedef struct packed {
        logic              kind;
        logic [IDX_W-1:0]  word_index;
        logic [WORD_W-1:0] payload_word;
        logic              last;
    } frame_result_t;

    logic [RX_W-1:0] frame_bytes [FRAME_LEN];
    int              fill_level = 0;
    frame_result_t   results_q [$];
    int              errors = 0;

    // Collect one byte; on a full frame run the CRC and queue the words or the error.
    task automatic absorb_byte(input logic [RX_W-1:0] b);
        logic [CRC_W-1:0]  crc;
        logic [WORD_W-1:0] w;
        int                hit;
        int                p;
        if (fill_level == 0 && b != SYNC_A) return;
        if (fill_level == 1 && b != SYNC_B) begin
            fill_level = 0;
            return;
        end
        frame_bytes[fill_level] = b;
        fill_level++;
        if (fill_level < FRAME_LEN) return;

        crc = CRC_INIT;
        for (int i = 0; i < FRAME_LEN; i++) crc = crc16_step(crc, frame_bytes[i]);

        if (crc == '0) begin
            for (int i = 0; i < PAYLOAD_WORDS; i++) begin
                p = 2 + 4 * i;
                w = {frame_bytes[p+3], frame_bytes[p+2], frame_bytes[p+1], frame_bytes[p]};
                results_q.push_back('{KIND_WORD, i[IDX_W-1:0], w, (i == PAYLOAD_WORDS - 1)});
            end
            fill_level = 0;
            return;
        end

        results_q.push_back('{KIND_ERR, '0, '0, 1'b1});
        // first sync pair past the header wins; shift the frame down to it
        hit = -1;
        for (int i = 2; i + 1 < FRAME_LEN && hit < 0; i++) begin
            if (frame_bytes[i] == SYNC_A && frame_bytes[i+1] == SYNC_B) hit = i;
        end
        if (hit >= 0) begin
            for (int i = 0; i < FRAME_LEN - hit; i++) frame_bytes[i] = frame_bytes[i+hit];
            fill_level = FRAME_LEN - hit;
        end else if (frame_bytes[FRAME_LEN-1] == SYNC_A) begin
            frame_bytes[0] = SYNC_A;
            fill_level = 1;
        end else begin
            fill_level = 0;
        end
    endtask

    always @(posedge aclk) begin
        frame_result_t due;
        if (!aresetn) begin
            fill_level = 0;
            results_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (results_q.size() == 0) begin
                    if (errors < 10)
                        $display("%0t: unexpected beat kind=%0d idx=%0d word=%h last=%0d",
                                 $realtime, m_kind, m_word_index, m_payload_word, m_last);
                    errors++;
                end else begin
                    due = results_q.pop_front();
                    if (m_kind !== due.kind || m_word_index !== due.word_index ||
                        m_payload_word !== due.payload_word || m_last !== due.last) begin
                        if (errors < 10)
                            $display("%0t: mismatch exp kind=%0d idx=%0d word=%h last=%0d %s",
                                     $realtime, due.kind, due.word_index, due.payload_word,
                                     due.last,
                                     $sformatf("got kind=%0d idx=%0d word=%h last=%0d",
                                               m_kind, m_word_index, m_payload_word,
                                               m_last));
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) absorb_byte(s_rx_byte);
        end
        mismatch_count <= errors;
        results_due    <= results_q.size();
    end

endmodule

[tb/sv/sync_crc_frame_receiver_tb.sv]
// Testbench top: byte stimulus, output stall pattern and verdict for the frame receiver.
module sync_crc_frame_receiver_tb;

    import scfr_pkg::*;
    import scfr_tb_pkg::*;

    localparam int ITEM_TARGET = 430;
    localparam int TAIL_CYCLES = 200;       // a bit over one full frame pass
    localparam int CYCLE_LIMIT = 200000;

    // Shapes of byte sequences the sender produces.
    typedef enum int {
        SCEN_GOOD,      // well-formed frame, correct CRC
        SCEN_BITFLIP,   // well-formed frame with one bit hit after the sync pair
        SCEN_RESYNC,    // bad frame whose tail is the start of a good frame
        SCEN_TRAIL,     // bad frame with no sync pair past the header, ending in the first sync byte
        SCEN_NOISE      // short run of random bytes, sync bytes mixed in
    } scen_e;

    typedef enum int {PAY_RANDOM, PAY_ZERO, PAY_ONES} payload_e;

    typedef enum logic [1:0] {
        RDY_ALWAYS,
        RDY_ONE_IN_THREE,
        RDY_COIN,
        RDY_SPARSE
    } ready_mode_e;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    logic [RX_W-1:0]   s_rx_byte = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    logic              m_kind;
    logic [IDX_W-1:0]  m_word_index;
    logic [WORD_W-1:0] m_payload_word;
    logic              m_last;

    int                mismatch_count;
    int                results_due;

    int                sent_bytes = 0;
    int                burst_left = 0;
    int                cycle_count = 0;
    ready_mode_e       ready_mode = RDY_ALWAYS;
    int                ready_left = 0;
    logic [7:0]        ready_tick = '0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    sync_crc_frame_receiver i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_word_index   (m_word_index),
        .m_payload_word (m_payload_word),
        .m_last         (m_last)
    );

    scfr_deframe_checker i_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_kind         (m_kind),
        .m_word_index   (m_word_index),
        .m_payload_word (m_payload_word),
        .m_last         (m_last),
        .mismatch_count (mismatch_count),
        .results_due    (results_due)
    );

    // Receiver stalls: switch at random between four ready patterns, one of them fully
    // open so that long runs without back-pressure occur too.
    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            ready_left <= $urandom_range(32, 200);
        end else begin
            ready_left <= ready_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS:       m_ready <= 1'b1;
            RDY_ONE_IN_THREE: m_ready <= (ready_tick % 3 == 0);
            RDY_COIN:         m_ready <= ($urandom_range(0, 3) != 0);
            default:          m_ready <= (ready_tick[3:0] == 4'd0);
        endcase
        ready_tick <= ready_tick + 1'b1;
    end

    // Watchdog: end the run if the block hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("watchdog expired after %0d cycles", CYCLE_LIMIT);
            $display("[sync_crc_frame_receiver] ERROR");
            $finish;
        end
    end

    // Drive one beat and hold it until the block takes it. The sender works in
    // bursts: at the start of each burst it may drop valid for a random gap.
    task automatic send_byte(input logic [RX_W-1:0] b);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            burst_left = $urandom_range(1, 40);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_bytes++;
    endtask

    task automatic send_span(input frame_t f, input int lo, input int hi);
        for (int i = lo; i <= hi; i++) send_byte(f[i]);
    endtask

    // Pause the sender until the checker has seen every result it predicted.
    // The first wait lets the due count catch up with the last accepted beat.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_due != 0) @(posedge aclk);
    endtask

    // Build a frame with a correct CRC, appended low byte first so the residue is zero.
    task automatic make_good_frame(output frame_t f, input payload_e fill);
        logic [CRC_W-1:0] crc;
        f[0] = SYNC_A;
        f[1] = SYNC_B;
        for (int i = 2; i < FRAME_LEN - 2; i++) begin
            case (fill)
                PAY_ZERO: f[i] = 8'h00;
                PAY_ONES: f[i] = 8'hFF;
                default:  f[i] = RX_W'($urandom_range(0, 255));
            endcase
        end
        crc = CRC_INIT;
        for (int i = 0; i < FRAME_LEN - 2; i++) crc = crc16_step(crc, f[i]);
        f[FRAME_LEN-2] = crc[7:0];
        f[FRAME_LEN-1] = crc[15:8];
    endtask

    function automatic payload_e pick_payload();
        case ($urandom_range(0, 5))
            0:       return PAY_ZERO;
            1:       return PAY_ONES;
            default: return PAY_RANDOM;
        endcase
    endfunction

    initial begin
        // Hunting and second-sync cases: the store is left empty again after these bytes.
        logic [RX_W-1:0] hunt_bytes [11] = '{8'h00, 8'hFF, SYNC_B, 8'd116, 8'd118,
                                             SYNC_A, SYNC_A, SYNC_A, 8'h00, SYNC_A, 8'hFF};
        scen_e           opening [4] = '{SCEN_RESYNC, SCEN_TRAIL, SCEN_GOOD, SCEN_BITFLIP};
        scen_e           mix [10] = '{SCEN_GOOD, SCEN_GOOD, SCEN_GOOD, SCEN_BITFLIP,
                                      SCEN_BITFLIP, SCEN_RESYNC, SCEN_RESYNC, SCEN_TRAIL,
                                      SCEN_TRAIL, SCEN_NOISE};
        frame_t          lead;
        frame_t          next_frame;
        scen_e           scen;
        int              scen_n;
        int              pos;
        int              run_len;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (hunt_bytes[i]) send_byte(hunt_bytes[i]);
        drain_results();

        scen_n = 0;
        while (sent_bytes < ITEM_TARGET) begin
            scen = (scen_n < 4) ? opening[scen_n] : mix[$urandom_range(0, 9)];
            case (scen)
                SCEN_GOOD: begin
                    // the good frame of the opening carries all-ones words
                    make_good_frame(next_frame, (scen_n < 4) ? PAY_ONES : pick_payload());
                    send_span(next_frame, 0, FRAME_LEN - 1);
                end
                SCEN_BITFLIP: begin
                    make_good_frame(lead, pick_payload());
                    pos = $urandom_range(2, FRAME_LEN - 1);
                    lead[pos][3'($urandom_range(0, 7))] ^= 1'b1;
                    send_span(lead, 0, FRAME_LEN - 1);
                end
                SCEN_RESYNC: begin
                    // Place the start of a good frame at pos inside a bad one, then
                    // finish the good frame; hit both ends of the search window.
                    make_good_frame(next_frame, (scen_n < 4) ? PAY_ZERO : pick_payload());
                    case ($urandom_range(0, 3))
                        0:       pos = 2;
                        1:       pos = FRAME_LEN - 2;
                        default: pos = $urandom_range(2, FRAME_LEN - 2);
                    endcase
                    if (scen_n < 4) pos = FRAME_LEN - 2;
                    lead[0] = SYNC_A;
                    lead[1] = SYNC_B;
                    for (int i = 2; i < pos; i++) begin
                        lead[i] = RX_W'($urandom_range(0, 255));
                        if (lead[i] == SYNC_A) lead[i] = ~SYNC_A;
                    end
                    for (int i = pos; i < FRAME_LEN; i++) lead[i] = next_frame[i-pos];
                    send_span(lead, 0, FRAME_LEN - 1);
                    send_span(next_frame, FRAME_LEN - pos, FRAME_LEN - 1);
                end
                SCEN_TRAIL: begin
                    // No sync pair past the header, last byte is the first sync byte: the
                    // block keeps it, so a good frame minus its first byte follows.
                    make_good_frame(next_frame, pick_payload());
                    lead[0] = SYNC_A;
                    lead[1] = SYNC_B;
                    for (int i = 2; i < FRAME_LEN - 1; i++) begin
                        lead[i] = RX_W'($urandom_range(0, 255));
                        if (lead[i] == SYNC_A) lead[i] = ~SYNC_A;
                    end
                    lead[FRAME_LEN-1] = SYNC_A;
                    send_span(lead, 0, FRAME_LEN - 1);
                    send_span(next_frame, 1, FRAME_LEN - 1);
                end
                default: begin
                    // Noise, sometimes opening like a frame; it may leave a partial
                    // frame behind that the next sequence then runs into.
                    run_len = $urandom_range(1, 24);
                    for (int i = 0; i < run_len; i++) begin
                        case ($urandom_range(0, 5))
                            0:       lead[0] = SYNC_A;
                            1:       lead[0] = SYNC_B;
                            default: lead[0] = RX_W'($urandom_range(0, 255));
                        endcase
                        if (i < 2 && $urandom_range(0, 1) == 0)
                            lead[0] = (i == 0) ? SYNC_A : SYNC_B;
                        send_byte(lead[0]);
                    end
                end
            endcase
            // let the output side catch up completely at least once
            if (scen_n == 1 || $urandom_range(0, 3) == 0) drain_results();
            scen_n++;
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (mismatch_count == 0 && results_due == 0) begin
            $display("[sync_crc_frame_receiver] OK");
        end else begin
            $display("[sync_crc_frame_receiver] ERROR");
        end
        $finish;
    end

endmodule
